// ===== hdl/lambert_w_newton_assert.svh =====
// Assertion macros for the Lambert W block; clk and arst_n come from the using scope.
`ifndef LAMBERT_W_NEWTON_ASSERT_SVH
`define LAMBERT_W_NEWTON_ASSERT_SVH

// Same-cycle implication.
`define LWN_ASSERT_NOW(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LWN_ASSERT_NEXT(lbl, cond, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lwn_pkg.sv =====
package lwn_pkg;

	localparam int IQ        = 30;
	localparam int YW        = 36;
	localparam int LW        = 40;
	localparam int EW        = 56;
	localparam int QW        = 37;
	localparam int CNT_W     = 6;
	localparam int ITER_W    = 7;
	localparam int TOL_W     = 8;
	localparam int RES_SHIFT = 6;
	localparam int EXP_TERMS = 14;
	localparam int W_W       = 24;

	localparam logic [29:0]          LN2     = 30'd744261118;
	localparam logic [YW-1:0]        Y_MAX   = 36'h8_0000_0000;
	localparam logic signed [LW-1:0] Z_MIN   = 40'shF8_0000_0000;
	localparam logic signed [LW-1:0] Z_MAX   = 40'sh04_4000_0000;
	localparam logic signed [17:0]   INV_LN2 = 18'sd94548;

	// floor((2^32 - 1) / n), n = 1..14
	localparam logic [31:0] RECIP [16] = '{
		32'd0,         32'd4294967295, 32'd2147483647, 32'd1431655765,
		32'd1073741823, 32'd858993459, 32'd715827882,  32'd613566756,
		32'd536870911, 32'd477218588,  32'd429496729,  32'd390451572,
		32'd357913941, 32'd330382099,  32'd306783378,  32'd0
	};

	localparam logic [1:0] REG_ITER_LIMIT = 2'd0;
	localparam logic [1:0] REG_RES_TOL    = 2'd1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_LN_NORM,
		OP_LN_SQ,
		OP_LN_SCALE,
		OP_SET_Y,
		OP_EXP_K,
		OP_EXP_R,
		OP_EXP_FIX,
		OP_TAY_A,
		OP_TAY_B,
		OP_TAY_C,
		OP_EXP_SH,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_UPDATE,
		OP_FINISH
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] idx;
		logic             ln_y;
		logic             nc;
	} dp_cmd_t;

	typedef struct packed {
		logic x_zero;
		logic y_pos;
		logic conv;
		logic r_ok;
	} dp_stat_t;

endpackage

// ===== hdl/lambert_w_newton.sv =====
// Lambert W, principal branch, of an unsigned Q16.16 argument by Newton steps
// in the log domain; the result is unsigned Q8.16 with a not_converged flag.
// Input: pulse start with x_value while busy is low; that word is taken at the
// clock edge. busy stays high while the item is worked on.
// Output: done is high for exactly one cycle with w_value and not_converged;
// the receiver cannot stall, and results hold until the next item finishes.
// A new start is accepted in the same cycle that done is shown.
// Config: cfg_index/cfg_data written when cfg_valid is high (cfg_ready is
// always high). Index 0 sets iteration_limit, index 1 residual_tolerance.
// Write only while idle.
// Sequence: from the accepting edge the log of x is taken (normalize,
// 30 squaring passes on one multiplier, scale) before the first loop test.
// Each Newton step then takes the log of the estimate and the residual test
// (skipped while the estimate is zero), the exponential (14 Taylor terms,
// plus k corrections until the reduced argument lies in [0, ln2)) and the
// bit-serial divide. The loop ends when the residual test passes or the
// iteration limit is hit, and done follows.
// A zero argument skips the log and the Newton steps. Reset clears the
// controller and sets iteration_limit to 100 and residual_tolerance to 1.
module lambert_w_newton #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] x_value,
	output logic        done,
	output logic [23:0] w_value,
	output logic        not_converged,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [lwn_pkg::ITER_W-1:0] iter_limit_q;
	logic [lwn_pkg::TOL_W-1:0]  res_tol_q;
	lwn_pkg::dp_cmd_t           cmd;
	lwn_pkg::dp_stat_t          stat;

	// Registers are always writable; the controller reads them only while busy.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_limit_q <= 7'd100;
			res_tol_q    <= 8'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lwn_pkg::REG_ITER_LIMIT)
				iter_limit_q <= cfg_data[6:0];
			else if (cfg_index == lwn_pkg::REG_RES_TOL)
				res_tol_q <= cfg_data;
		end
	end

	// Sequence the log, exp, divide and update passes of each step.
	lwn_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.iter_limit (iter_limit_q),
		.stat       (stat),
		.cmd        (cmd),
		.busy       (busy),
		.done       (done)
	);

	// Hold the estimate and the multipliers, shifters and divider.
	lwn_dpath #(
		.FRAC_BITS (FRAC_BITS)
	) u_dpath (
		.clk           (clk),
		.x_value       (x_value),
		.res_tol       (res_tol_q),
		.cmd           (cmd),
		.stat          (stat),
		.w_value       (w_value),
		.not_converged (not_converged)
	);

`include "lambert_w_newton_assert.svh"

	`LWN_ASSERT_NOW(a_done_not_busy, done, !busy, "done while busy")
	`LWN_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	`LWN_ASSERT_NEXT(a_done_single, done, !done, "done held for more than one cycle")

endmodule

// ===== hdl/lwn_ctrl.sv =====
module lwn_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lwn_pkg::ITER_W-1:0]  iter_limit,
	input  lwn_pkg::dp_stat_t           stat,
	output lwn_pkg::dp_cmd_t            cmd,
	output logic                        busy,
	output logic                        done
);

	typedef enum logic [19:0] {
		S_IDLE     = 20'h00001,
		S_XCHK     = 20'h00002,
		S_LN_NORM  = 20'h00004,
		S_LN_SQ    = 20'h00008,
		S_LN_SCALE = 20'h00010,
		S_SET_Y    = 20'h00020,
		S_LOOP     = 20'h00040,
		S_CHECK    = 20'h00080,
		S_EXP_K    = 20'h00100,
		S_EXP_R    = 20'h00200,
		S_EXP_FIX  = 20'h00400,
		S_TAY_A    = 20'h00800,
		S_TAY_B    = 20'h01000,
		S_TAY_C    = 20'h02000,
		S_EXP_SH   = 20'h04000,
		S_DIV_INIT = 20'h08000,
		S_DIV_STEP = 20'h10000,
		S_UPDATE   = 20'h20000,
		S_FINISH   = 20'h40000,
		S_DONE     = 20'h80000
	} state_t;

	state_t                        state_q, state_d;
	logic [lwn_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [lwn_pkg::ITER_W-1:0]    iter_q, iter_d;
	logic                          ln_y_q, ln_y_d;
	logic                          nc_q, nc_d;
	lwn_pkg::dp_op_t               op;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		iter_d  = iter_q;
		ln_y_d  = ln_y_q;
		nc_d    = nc_q;
		op      = lwn_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE, S_DONE: begin
				if (start) begin
					op      = lwn_pkg::OP_LOAD;
					state_d = S_XCHK;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_XCHK: begin
				ln_y_d = 1'b0;
				if (stat.x_zero) begin
					nc_d    = 1'b0;
					state_d = S_FINISH;
				end else begin
					state_d = S_LN_NORM;
				end
			end
			S_LN_NORM: begin
				op      = lwn_pkg::OP_LN_NORM;
				cnt_d   = lwn_pkg::CNT_W'(lwn_pkg::IQ - 1);
				state_d = S_LN_SQ;
			end
			S_LN_SQ: begin
				op    = lwn_pkg::OP_LN_SQ;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_LN_SCALE;
			end
			S_LN_SCALE: begin
				op      = lwn_pkg::OP_LN_SCALE;
				state_d = ln_y_q ? S_CHECK : S_SET_Y;
			end
			S_SET_Y: begin
				op      = lwn_pkg::OP_SET_Y;
				iter_d  = '0;
				state_d = S_LOOP;
			end
			S_LOOP: begin
				if (iter_q == iter_limit) begin
					nc_d    = 1'b1;
					state_d = S_FINISH;
				end else if (stat.y_pos) begin
					ln_y_d  = 1'b1;
					state_d = S_LN_NORM;
				end else begin
					state_d = S_EXP_K;
				end
			end
			S_CHECK: begin
				if (stat.conv) begin
					nc_d    = 1'b0;
					state_d = S_FINISH;
				end else begin
					state_d = S_EXP_K;
				end
			end
			S_EXP_K: begin
				op      = lwn_pkg::OP_EXP_K;
				state_d = S_EXP_R;
			end
			S_EXP_R: begin
				op      = lwn_pkg::OP_EXP_R;
				state_d = S_EXP_FIX;
			end
			S_EXP_FIX: begin
				if (stat.r_ok) begin
					cnt_d   = lwn_pkg::CNT_W'(1);
					state_d = S_TAY_A;
				end else begin
					op = lwn_pkg::OP_EXP_FIX;
				end
			end
			S_TAY_A: begin
				op      = lwn_pkg::OP_TAY_A;
				state_d = S_TAY_B;
			end
			S_TAY_B: begin
				op      = lwn_pkg::OP_TAY_B;
				state_d = S_TAY_C;
			end
			S_TAY_C: begin
				op = lwn_pkg::OP_TAY_C;
				if (cnt_q == lwn_pkg::CNT_W'(lwn_pkg::EXP_TERMS)) begin
					state_d = S_EXP_SH;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = S_TAY_A;
				end
			end
			S_EXP_SH: begin
				op      = lwn_pkg::OP_EXP_SH;
				state_d = S_DIV_INIT;
			end
			S_DIV_INIT: begin
				op      = lwn_pkg::OP_DIV_INIT;
				cnt_d   = lwn_pkg::CNT_W'(lwn_pkg::QW - 1);
				state_d = S_DIV_STEP;
			end
			S_DIV_STEP: begin
				op    = lwn_pkg::OP_DIV_STEP;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == '0)
					state_d = S_UPDATE;
			end
			S_UPDATE: begin
				op      = lwn_pkg::OP_UPDATE;
				iter_d  = iter_q + 1'b1;
				state_d = S_LOOP;
			end
			S_FINISH: begin
				op      = lwn_pkg::OP_FINISH;
				state_d = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			iter_q  <= '0;
			ln_y_q  <= 1'b0;
			nc_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			iter_q  <= iter_d;
			ln_y_q  <= ln_y_d;
			nc_q    <= nc_d;
		end
	end

	assign cmd.op   = op;
	assign cmd.idx  = cnt_q;
	assign cmd.ln_y = ln_y_q;
	assign cmd.nc   = nc_q;
	assign busy     = !(state_q == S_IDLE || state_q == S_DONE);
	assign done     = (state_q == S_DONE);

endmodule

// ===== hdl/lwn_dpath.sv =====
module lwn_dpath #(
	parameter int FRAC_BITS = 16
) (
	input  logic                       clk,
	input  logic [31:0]                x_value,
	input  logic [lwn_pkg::TOL_W-1:0]  res_tol,
	input  lwn_pkg::dp_cmd_t           cmd,
	output lwn_pkg::dp_stat_t          stat,
	output logic [lwn_pkg::W_W-1:0]    w_value,
	output logic                       not_converged
);

	localparam int YW = lwn_pkg::YW;
	localparam int LW = lwn_pkg::LW;
	localparam int EW = lwn_pkg::EW;
	localparam int QW = lwn_pkg::QW;
	localparam int OSH = lwn_pkg::IQ - FRAC_BITS;

	logic [31:0]            x_q;
	logic [YW-1:0]          y_q;
	logic signed [LW-1:0]   lnx_q, ln_q;
	logic [30:0]            m_q;
	logic [29:0]            frac_q;
	logic signed [7:0]      pint_q;
	logic signed [LW-1:0]   z_q, r_q;
	logic signed [7:0]      k_q;
	logic [30:0]            term_q, qe_q;
	logic [31:0]            sum_q;
	logic [EW-1:0]          e_q;
	logic [YW-1:0]          rem_q, d_q;
	logic [6:0]             nlo_q;
	logic [QW-1:0]          quo_q;
	logic                   neg_q, ovf_q;
	logic [lwn_pkg::W_W-1:0] w_q;
	logic                   nc_q;

	// normalize
	logic [YW-1:0] src;
	logic [5:0]    lead;
	logic [YW-1:0] norm;
	always_comb begin
		src  = cmd.ln_y ? y_q : {4'b0, x_q};
		lead = '0;
		for (int i = 0; i < YW; i++)
			if (src[i]) lead = 6'(i);
		norm = src << (6'(YW - 1) - lead);
	end

	// square step
	logic [61:0] sq;
	logic [31:0] ms;
	assign sq = 62'(m_q) * 62'(m_q);
	assign ms = sq[61:30];

	// scale by ln2
	logic signed [37:0] la;
	logic [37:0]        lam;
	logic [59:0]        lop;
	logic [LW-1:0]      lr;
	always_comb begin
		la  = {pint_q, frac_q};
		lam = la[37] ? 38'(-la) : 38'(la);
		lop = 60'(lam[29:0]) * 60'(lwn_pkg::LN2);
		lr  = LW'(lam[37:30]) * LW'(lwn_pkg::LN2)
			+ LW'((lop + 60'(1 << 29)) >> 30);
	end

	// residual
	logic signed [41:0] res;
	logic [41:0]        rm;
	assign res = {{2{lnx_q[LW-1]}}, lnx_q} - {{2{ln_q[LW-1]}}, ln_q} - {6'b0, y_q};
	assign rm  = res[41] ? 42'(-res) : 42'(res);

	// exp argument and k estimate
	logic signed [LW:0] Z_MIN_EXT, Z_MAX_EXT;
	assign Z_MIN_EXT = {lwn_pkg::Z_MIN[LW-1], lwn_pkg::Z_MIN};
	assign Z_MAX_EXT = {lwn_pkg::Z_MAX[LW-1], lwn_pkg::Z_MAX};

	logic signed [LW:0]   zdiff;
	logic signed [LW-1:0] zs;
	logic signed [23:0]   zh;
	logic signed [41:0]   kprod;
	logic signed [LW-1:0] kln;
	always_comb begin
		zdiff = {lnx_q[LW-1], lnx_q} - {5'b0, y_q};
		if (zdiff < Z_MIN_EXT)
			zs = lwn_pkg::Z_MIN;
		else if (zdiff > Z_MAX_EXT)
			zs = lwn_pkg::Z_MAX;
		else
			zs = zdiff[LW-1:0];
		zh    = zs[LW-1:16];
		kprod = zh * lwn_pkg::INV_LN2;
		kln   = k_q * $signed({1'b0, lwn_pkg::LN2});
	end

	// Taylor terms
	logic [60:0] tp;
	logic [62:0] qp;
	logic [34:0] qn;
	logic [34:0] trem;
	logic [30:0] qfix;
	always_comb begin
		tp   = 61'(term_q) * 61'(r_q[29:0]);
		qp   = 63'(term_q) * 63'(lwn_pkg::RECIP[cmd.idx[3:0]]);
		qn   = 35'(qe_q) * 35'(cmd.idx[3:0]);
		trem = 35'(term_q) - qn;
		qfix = (trem >= 35'(cmd.idx[3:0])) ? qe_q + 31'd1 : qe_q;
	end

	// scale by 2^k
	logic [5:0]    rsh;
	logic [EW-1:0] esh;
	always_comb begin
		rsh = 6'(-k_q);
		if (!k_q[7])
			esh = EW'(sum_q) << k_q[4:0];
		else
			esh = (EW'(sum_q) + (EW'(1) << (rsh - 6'd1))) >> rsh;
	end

	// divider setup
	logic signed [57:0] num;
	logic [57:0]        mag;
	logic [YW-1:0]      dv;
	assign num = $signed({22'b0, y_q}) - $signed({2'b0, e_q});
	assign mag = num[57] ? 58'(-num) : 58'(num);
	assign dv  = y_q + YW'(1 << lwn_pkg::IQ);

	// divider step
	logic [QW-1:0] nbits;
	logic [YW:0]   dt;
	logic          dge;
	assign nbits = {nlo_q, 30'b0};
	assign dt    = {rem_q, nbits[cmd.idx]};
	assign dge   = dt >= {1'b0, d_q};

	// estimate update
	logic signed [LW-1:0] ny;
	logic [YW-1:0]        ycl;
	always_comb begin
		ny = neg_q ? $signed({4'b0, y_q}) + $signed({3'b0, quo_q})
			: $signed({4'b0, y_q}) - $signed({3'b0, quo_q});
		if (ovf_q)
			ycl = neg_q ? lwn_pkg::Y_MAX : '0;
		else if (ny < 0)
			ycl = '0;
		else if (ny > $signed({4'b0, lwn_pkg::Y_MAX}))
			ycl = lwn_pkg::Y_MAX;
		else
			ycl = ny[YW-1:0];
	end

	// output rounding
	logic [YW:0] wsum, wsh;
	assign wsum = {1'b0, y_q} + ((YW + 1)'(1) << (OSH - 1));
	assign wsh  = wsum >> OSH;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lwn_pkg::OP_NONE: begin
			end
			lwn_pkg::OP_LOAD: begin
				x_q <= x_value;
				y_q <= '0;
			end
			lwn_pkg::OP_LN_NORM: begin
				m_q    <= norm[YW-1:5];
				frac_q <= '0;
				pint_q <= cmd.ln_y ? 8'($signed({2'b0, lead}) - 8'sd30)
					: 8'($signed({2'b0, lead}) - 8'(FRAC_BITS));
			end
			lwn_pkg::OP_LN_SQ: begin
				if (ms[31]) begin
					m_q                  <= ms[31:1];
					frac_q[cmd.idx[4:0]] <= 1'b1;
				end else begin
					m_q <= ms[30:0];
				end
			end
			lwn_pkg::OP_LN_SCALE: begin
				ln_q <= la[37] ? -$signed(lr) : $signed(lr);
			end
			lwn_pkg::OP_SET_Y: begin
				lnx_q <= ln_q;
				if (ln_q <= 0)
					y_q <= '0;
				else if (ln_q > $signed({4'b0, lwn_pkg::Y_MAX}))
					y_q <= lwn_pkg::Y_MAX;
				else
					y_q <= ln_q[YW-1:0];
			end
			lwn_pkg::OP_EXP_K: begin
				z_q <= zs;
				k_q <= kprod[37:30];
			end
			lwn_pkg::OP_EXP_R: begin
				r_q    <= z_q - kln;
				term_q <= 31'(1 << lwn_pkg::IQ);
				sum_q  <= 32'(1 << lwn_pkg::IQ);
			end
			lwn_pkg::OP_EXP_FIX: begin
				if (r_q[LW-1]) begin
					r_q <= r_q + $signed({10'b0, lwn_pkg::LN2});
					k_q <= k_q - 8'sd1;
				end else begin
					r_q <= r_q - $signed({10'b0, lwn_pkg::LN2});
					k_q <= k_q + 8'sd1;
				end
			end
			lwn_pkg::OP_TAY_A: begin
				term_q <= 31'((tp + 61'(1 << 29)) >> 30);
			end
			lwn_pkg::OP_TAY_B: begin
				qe_q <= qp[62:32];
			end
			lwn_pkg::OP_TAY_C: begin
				term_q <= qfix;
				sum_q  <= sum_q + 32'(qfix);
			end
			lwn_pkg::OP_EXP_SH: begin
				e_q <= esh;
			end
			lwn_pkg::OP_DIV_INIT: begin
				neg_q <= num[57];
				d_q   <= dv;
				ovf_q <= mag >= 58'({dv, 6'b0});
				rem_q <= YW'(mag >> 7);
				nlo_q <= mag[6:0];
				quo_q <= '0;
			end
			lwn_pkg::OP_DIV_STEP: begin
				if (dge)
					rem_q <= YW'(dt - {1'b0, d_q});
				else
					rem_q <= dt[YW-1:0];
				quo_q <= {quo_q[QW-2:0], dge};
			end
			lwn_pkg::OP_UPDATE: begin
				y_q <= ycl;
			end
			lwn_pkg::OP_FINISH: begin
				w_q  <= (wsh > (YW + 1)'(24'hFFFFFF)) ? 24'hFFFFFF : wsh[23:0];
				nc_q <= cmd.nc;
			end
			default: begin
			end
		endcase
	end

	assign stat.x_zero = (x_q == '0);
	assign stat.y_pos  = (y_q != '0);
	assign stat.conv   = (rm >> lwn_pkg::RES_SHIFT) < 42'(res_tol);
	assign stat.r_ok   = !r_q[LW-1] && (r_q < $signed({10'b0, lwn_pkg::LN2}));
	assign w_value       = w_q;
	assign not_converged = nc_q;

endmodule

// ===== tb/lwn_checker.sv =====
`timescale 1ns / 1ps

module lwn_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] x_value,
	input  logic        done,
	input  logic [23:0] w_value,
	input  logic        not_converged,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          errors,
	output int          pending
);

	localparam longint      ONE_Q   = 64'sd1 <<< lwn_pkg::IQ;
	localparam longint      LN2_Q   = 64'sd744261118;
	localparam longint      EST_MAX = 64'sd32 <<< lwn_pkg::IQ;
	localparam longint      ARG_MIN = -(64'sd32 <<< lwn_pkg::IQ);
	localparam longint      ARG_MAX = 64'sd17 <<< lwn_pkg::IQ;
	localparam int          XFRAC   = 16;

	typedef struct packed {
		logic [23:0] w;
		logic        nc;
	} w_result_t;

	w_result_t    w_expected_q[$];
	logic [6:0]   iter_limit;
	logic [7:0]   res_tol;

	function automatic longint mul_ln2(longint a);
		longint unsigned m, hi, lo, r;
		m  = (a < 0) ? longint'(-a) : longint'(a);
		hi = m >> lwn_pkg::IQ;
		lo = m & ((64'd1 << lwn_pkg::IQ) - 1);
		r  = hi * LN2_Q + ((lo * LN2_Q + (64'd1 << (lwn_pkg::IQ - 1))) >> lwn_pkg::IQ);
		return (a < 0) ? -longint'(r) : longint'(r);
	endfunction

	// natural log of v * 2^-s in Q.30
	function automatic longint ln_q30(longint unsigned v, int s);
		int p;
		longint unsigned m, frac;
		p    = 63;
		frac = 0;
		while (p > 0 && v[p] == 1'b0) p--;
		m = (p >= lwn_pkg::IQ) ? (v >> (p - lwn_pkg::IQ)) : (v << (lwn_pkg::IQ - p));
		for (int i = lwn_pkg::IQ - 1; i >= 0; i--) begin
			m = (m * m) >> lwn_pkg::IQ;
			if (m >= (64'd2 << lwn_pkg::IQ)) begin
				m = m >> 1;
				frac |= 64'd1 << i;
			end
		end
		return mul_ln2(longint'(p - s) * ONE_Q + longint'(frac));
	endfunction

	function automatic longint unsigned exp_q30(longint z);
		longint k, r;
		longint unsigned sum, term;
		sum  = ONE_Q;
		term = ONE_Q;
		if (z < ARG_MIN) z = ARG_MIN;
		if (z > ARG_MAX) z = ARG_MAX;
		k = z / LN2_Q;
		if (z < 0 && k * LN2_Q != z) k--;
		r = z - k * LN2_Q;
		for (int n = 1; n <= lwn_pkg::EXP_TERMS; n++) begin
			term = (term * longint'(r) + (64'd1 << (lwn_pkg::IQ - 1))) >> lwn_pkg::IQ;
			term = term / n;
			sum += term;
		end
		if (k >= 0) return sum << k;
		if (-k >= 62) return 0;
		return (sum + (64'd1 << (-k - 1))) >> (-k);
	endfunction

	function automatic longint unsigned div_q30(longint unsigned n, longint unsigned d);
		longint unsigned q, rem;
		q   = n / d;
		rem = n % d;
		for (int i = 0; i < lwn_pkg::IQ; i++) begin
			rem = rem << 1;
			q   = q << 1;
			if (rem >= d) begin
				rem -= d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic w_result_t lambert_w(logic [31:0] xv, logic [6:0] lim, logic [7:0] tol);
		w_result_t res;
		longint lnx, y, resid, num, e;
		longint unsigned rm, mag, d, w;
		int i;
		if (xv == 0) begin
			res.w  = '0;
			res.nc = 1'b0;
			return res;
		end
		lnx = ln_q30(xv, XFRAC);
		y   = (lnx > 0) ? lnx : 0;
		if (y > EST_MAX) y = EST_MAX;
		for (i = 0; i < lim; i++) begin
			// a zero estimate has no finite residual: step without testing
			if (y > 0) begin
				resid = lnx - ln_q30(y, lwn_pkg::IQ) - y;
				rm    = (resid < 0) ? longint'(-resid) : longint'(resid);
				if ((rm >> lwn_pkg::RES_SHIFT) < tol) break;
			end
			e   = longint'(exp_q30(lnx - y));
			num = y - e;
			mag = (num < 0) ? longint'(-num) : longint'(num);
			d   = div_q30(mag, y + ONE_Q);
			y   = (num >= 0) ? y - longint'(d) : y + longint'(d);
			if (y < 0) y = 0;
			if (y > EST_MAX) y = EST_MAX;
		end
		w      = (longint'(y) + (64'd1 << (lwn_pkg::IQ - XFRAC - 1))) >> (lwn_pkg::IQ - XFRAC);
		res.w  = (w > 64'hFF_FFFF) ? 24'hFF_FFFF : w[23:0];
		res.nc = (i == lim);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		w_result_t got, want;
		int        nerr;
		if (!arst_n) begin
			iter_limit <= 7'd100;
			res_tol    <= 8'd1;
			errors     <= 0;
			pending    <= 0;
			w_expected_q.delete();
		end else begin
			nerr = 0;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lwn_pkg::REG_ITER_LIMIT) iter_limit <= cfg_data[6:0];
				else if (cfg_index == lwn_pkg::REG_RES_TOL) res_tol <= cfg_data;
			end
			if (start && !busy) w_expected_q.push_back(lambert_w(x_value, iter_limit, res_tol));
			if (done) begin
				got.w  = w_value;
				got.nc = not_converged;
				if (w_expected_q.size() == 0) begin
					$error("unexpected result w_value %h not_converged %b", got.w, got.nc);
					nerr++;
				end else begin
					want = w_expected_q.pop_front();
					if (got.w !== want.w) begin
						$error("w_value expected %h got %h", want.w, got.w);
						nerr++;
					end
					if (got.nc !== want.nc) begin
						$error("not_converged expected %b got %b", want.nc, got.nc);
						nerr++;
					end
				end
			end
			errors  <= errors + nerr;
			pending <= w_expected_q.size();
		end
	end

endmodule

// ===== tb/tb_lambert_w_newton.sv =====
`timescale 1ns / 1ps

module tb_lambert_w_newton;

	// Longest legal silence is one item at 100 Newton steps.
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int NUM_PHASES     = 7;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic [31:0] x_value       = '0;
	logic        cfg_valid     = 1'b0;
	logic [1:0]  cfg_index     = lwn_pkg::REG_ITER_LIMIT;
	logic [7:0]  cfg_data      = '0;
	logic        busy;
	logic        done;
	logic [23:0] w_value;
	logic        not_converged;
	logic        cfg_ready;
	int          errors;
	int          pending;
	int          word_count;

	// Phase plan: iteration limit write, tolerance write, random word count.
	// Phase 0 runs the directed words under the reset settings.
	logic [7:0] phase_limit [NUM_PHASES] = '{8'd100, 8'd100, 8'd1, 8'd7, 8'd0, 8'd100, 8'd148};
	logic [7:0] phase_tol   [NUM_PHASES] = '{8'd1,   8'd1,   8'd0, 8'd255, 8'd17, 8'd0, 8'd128};
	int         phase_words [NUM_PHASES] = '{0,      170,    110,  150,    70,    4,    160};

	logic [31:0] directed_x [18] = '{
		32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000,
		32'h0000_FFFF, 32'h0001_0001, 32'h0002_B7E1, 32'h8000_0000,
		32'h7FFF_FFFF, 32'h0000_0002, 32'h0000_8000, 32'h0000_0100,
		32'h00FF_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h0000_0003, 32'h0010_0000
	};

	always #5 clk = ~clk;

	lambert_w_newton dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.x_value      (x_value),
		.done         (done),
		.w_value      (w_value),
		.not_converged(not_converged),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	lwn_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.x_value      (x_value),
		.done         (done),
		.w_value      (w_value),
		.not_converged(not_converged),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending)
	);

	// Pick an argument spread over the whole log range; mostly nonzero.
	function automatic logic [31:0] random_x();
		logic [31:0] v;
		if ($urandom_range(0, 99) < 2) return '0;
		v = $urandom();
		if ($urandom_range(0, 3) != 0) v = v >> $urandom_range(0, 31);
		return (v == 0) ? 32'd1 : v;
	endfunction

	// Hold start low for a random gap, except in the quiet window of words.
	task automatic idle_gap();
		int gap;
		gap = 0;
		if ((word_count < 300 || word_count >= 420) && $urandom_range(0, 99) < 38)
			gap = $urandom_range(1, 150);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Present one word and hold it until the block takes it.
	task automatic send_word(logic [31:0] xv);
		idle_gap();
		start   <= 1'b1;
		x_value <= xv;
		do @(posedge clk); while (busy);
		word_count++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] data);
		if ($urandom_range(0, 99) < 38) repeat ($urandom_range(1, 8)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Drop start, then wait until every result is back and the block is idle.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0 || busy) @(posedge clk);
	endtask

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done || (cfg_valid && cfg_ready) || !arst_n) quiet = 0;
			else quiet++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		word_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under reset settings: zero, extremes, x = 1, x = e.
		foreach (directed_x[i]) send_word(directed_x[i]);

		// Random phases; extremes include a zero limit (data 0), zero
		// tolerance, full tolerance, and a limit written with bit 7 set.
		for (int ph = 1; ph < NUM_PHASES; ph++) begin
			drain();
			write_reg(lwn_pkg::REG_ITER_LIMIT, phase_limit[ph]);
			write_reg(lwn_pkg::REG_RES_TOL, phase_tol[ph]);
			for (int n = 0; n < phase_words[ph]; n++) send_word(random_x());
		end

		drain();
		repeat (60) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
